[rtl/core/mwnv_pkg.sv]
// Shared constants, types and register codes for the masked window normal variance block.
// No dependencies; every other file in rtl/core except mwnv_ram imports this package.

package mwnv_pkg;

    // Window and image geometry
    localparam int HALF_WINDOW = 2;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int WIN         = 2 * HALF_WINDOW + 1;
    localparam int WIN_N       = WIN * WIN;
    localparam int WIN_W       = $clog2(WIN);

    // Pixel store
    localparam int STORE_DEPTH = WIN * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COMP_W      = 16;
    localparam int ENTRY_W     = 3 * COMP_W + 1;

    // Counters and geometry
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 4;
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W     = $clog2(MAX_HEIGHT + 1);
    localparam int EXT_W     = (WID_W > CFG_W) ? WID_W : CFG_W;
    localparam int GEO_W     = ((WID_W > HGT_W) ? WID_W : HGT_W) + 1;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int PIX_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int POS_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + HALF_WINDOW * MAX_WIDTH
                                      + HALF_WINDOW + 1);

    // Statistics and arithmetic widths
    localparam int CNT_W   = $clog2(WIN_N + 1);
    localparam int MSTEP_W = $clog2(CNT_W);
    localparam int SUM_W   = COMP_W + CNT_W;
    localparam int SQ1_W   = 2 * COMP_W;
    localparam int SQ_W    = SQ1_W + CNT_W;
    localparam int PROD_W  = SQ_W + CNT_W;
    localparam int NUM_W   = PROD_W + 2;
    localparam int DEN_W   = 2 * CNT_W;
    localparam int QCNT_W  = $clog2(NUM_W + 1);
    localparam int VAR_W   = 31;
    localparam logic [VAR_W-1:0] VAR_SAT = 31'h4000_0000;

    // Port widths
    localparam int OUT_IDX_W  = 10;
    localparam int IN_DATA_W  = 3 * COMP_W;
    localparam int OUT_USED_W = VAR_W + 2 * OUT_IDX_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;
    localparam logic [CFG_W-1:0]     FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0]     FRAME_HEIGHT_RST = 11'd480;

    // Tag that travels with each window read
    typedef struct packed {
        logic valid;
        logic in_image;
        logic center;
    } rd_tag_t;

    // Window sums handed from the accumulator to the variance unit
    typedef struct packed {
        logic [CNT_W-1:0]        cnt;
        logic [SQ_W-1:0]         sq;
        logic signed [SUM_W-1:0] s0;
        logic signed [SUM_W-1:0] s1;
        logic signed [SUM_W-1:0] s2;
        logic                    cv;
    } win_stat_t;

endpackage

[rtl/core/mwnv_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.

module mwnv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read; read data is registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/mwnv_acc.sv]
// Window accumulator: squares each stored word read back and sums count, squares and components.
// Depends on mwnv_pkg.

module mwnv_acc
    import mwnv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  rd_tag_t            tag,
    input  logic [ENTRY_W-1:0] rd_data,
    output win_stat_t          stat
);

    rd_tag_t                   tag1_reg;
    rd_tag_t                   tag2_reg;
    logic signed [COMP_W-1:0]  cx2_reg, cy2_reg, cz2_reg;
    logic [SQ1_W-1:0]          sq2_reg;
    logic                      pv2_reg;
    win_stat_t                 stat_reg;

    logic signed [COMP_W-1:0]  dx, dy, dz;
    logic signed [SQ1_W-1:0]   px, py, pz;
    logic [SQ1_W-1:0]          sq_sum;

    assign dx = rd_data[COMP_W-1:0];
    assign dy = rd_data[2*COMP_W-1:COMP_W];
    assign dz = rd_data[3*COMP_W-1:2*COMP_W];
    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;
    assign sq_sum = $unsigned(px) + $unsigned(py) + $unsigned(pz);

    // Align tags with read data, then with the squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag;
            tag2_reg <= tag1_reg;
        end
    end

    // Register squares and components
    always_ff @(posedge clk)
    begin
        cx2_reg <= dx;
        cy2_reg <= dy;
        cz2_reg <= dz;
        sq2_reg <= sq_sum;
        pv2_reg <= rd_data[ENTRY_W-1];
    end

    // Accumulate valid in-image neighbors; capture the center flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg <= '0;
        end
        else if (clear)
        begin
            stat_reg <= '0;
        end
        else
        begin
            if (tag2_reg.valid && tag2_reg.in_image && pv2_reg)
            begin
                stat_reg.cnt <= stat_reg.cnt + CNT_W'(1);
                stat_reg.sq  <= stat_reg.sq + SQ_W'(sq2_reg);
                stat_reg.s0  <= stat_reg.s0 + SUM_W'(cx2_reg);
                stat_reg.s1  <= stat_reg.s1 + SUM_W'(cy2_reg);
                stat_reg.s2  <= stat_reg.s2 + SUM_W'(cz2_reg);
            end
            if (tag2_reg.valid && tag2_reg.center)
            begin
                stat_reg.cv <= pv2_reg;
            end
        end
    end

    assign stat = stat_reg;

endmodule

[rtl/core/mwnv_var.sv]
// Variance unit: shift-add product cnt*S, squared sums, then a restoring divide by cnt^2.
// Depends on mwnv_pkg.

module mwnv_var
    import mwnv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  win_stat_t        stat,
    output logic             done,
    output logic [VAR_W-1:0] variance
);

    localparam logic [1:0] V_IDLE = 2'd0;
    localparam logic [1:0] V_MUL  = 2'd1;
    localparam logic [1:0] V_DIV  = 2'd2;

    logic [1:0]              vstate_reg;
    logic [MSTEP_W-1:0]      step_reg;
    logic [QCNT_W-1:0]       qcnt_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic signed [SUM_W-1:0] s0_reg, s1_reg, s2_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [NUM_W-1:0]        ss_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [NUM_W-1:0]        num_reg;
    logic                    done_reg;
    logic [VAR_W-1:0]        var_reg;

    logic signed [SUM_W-1:0]   s_sel;
    logic signed [2*SUM_W-1:0] s_sq;
    logic [PROD_W-1:0]         prod_next;
    logic [NUM_W-1:0]          ss_next;
    logic [NUM_W-1:0]          prod_ext;
    logic [NUM_W-1:0]          diff;
    logic [DEN_W:0]            trial;
    logic                      q_bit;

    // Pick one component sum per step
    always_comb
    begin
        case (step_reg)
            MSTEP_W'(0): s_sel = s0_reg;
            MSTEP_W'(1): s_sel = s1_reg;
            MSTEP_W'(2): s_sel = s2_reg;
            default:     s_sel = '0;
        endcase
    end

    assign s_sq      = s_sel * s_sel;
    assign prod_next = cnt_reg[step_reg] ? prod_reg + (PROD_W'(sq_reg) << step_reg) : prod_reg;
    assign ss_next   = ss_reg + NUM_W'($unsigned(s_sq));
    assign prod_ext  = NUM_W'(prod_next);
    assign diff      = (prod_ext > ss_next) ? prod_ext - ss_next : '0;
    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign q_bit     = (trial >= {1'b0, den_reg});

    // Sequence multiply, then divide
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vstate_reg <= V_IDLE;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (vstate_reg)
                V_IDLE:
                begin
                    if (start)
                    begin
                        if (stat.cv)
                        begin
                            vstate_reg <= V_MUL;
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                end
                V_MUL:
                begin
                    if (step_reg == MSTEP_W'(CNT_W - 1))
                    begin
                        vstate_reg <= V_DIV;
                    end
                end
                V_DIV:
                begin
                    if (qcnt_reg == QCNT_W'(NUM_W - 1))
                    begin
                        vstate_reg <= V_IDLE;
                        done_reg   <= 1'b1;
                    end
                end
                default:
                begin
                    vstate_reg <= V_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (vstate_reg)
            V_IDLE:
            begin
                cnt_reg  <= stat.cnt;
                sq_reg   <= stat.sq;
                s0_reg   <= stat.s0;
                s1_reg   <= stat.s1;
                s2_reg   <= stat.s2;
                den_reg  <= DEN_W'(stat.cnt) * DEN_W'(stat.cnt);
                prod_reg <= '0;
                ss_reg   <= '0;
                step_reg <= '0;
                if (start && !stat.cv)
                begin
                    var_reg <= '0;
                end
            end
            V_MUL:
            begin
                prod_reg <= prod_next;
                if (step_reg < MSTEP_W'(3))
                begin
                    ss_reg <= ss_next;
                end
                step_reg <= step_reg + MSTEP_W'(1);
                if (step_reg == MSTEP_W'(CNT_W - 1))
                begin
                    num_reg  <= diff << 2;
                    rem_reg  <= '0;
                    qcnt_reg <= '0;
                end
            end
            V_DIV:
            begin
                rem_reg  <= q_bit ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
                num_reg  <= {num_reg[NUM_W-2:0], q_bit};
                qcnt_reg <= qcnt_reg + QCNT_W'(1);
                if (qcnt_reg == QCNT_W'(NUM_W - 1))
                begin
                    if ({num_reg[NUM_W-2:0], q_bit} > NUM_W'(VAR_SAT))
                    begin
                        var_reg <= VAR_SAT;
                    end
                    else
                    begin
                        var_reg <= VAR_W'({num_reg[NUM_W-2:0], q_bit});
                    end
                end
            end
            default:
            begin
                step_reg <= '0;
            end
        endcase
    end

    assign done     = done_reg;
    assign variance = var_reg;

endmodule

[rtl/core/masked_window_normal_variance.sv]
// Top level of the masked window normal variance block: sequencer, geometry, output register.
// Depends on mwnv_pkg, mwnv_ram, mwnv_acc and mwnv_var.
//
// Usage:
//   s_axis carries one pixel per word: tdata holds normal x, y, z (Q1.14), tuser the
//   pixel valid flag. Send the frame in raster order, then HALF_WINDOW*width+HALF_WINDOW
//   padding words; the counter then wraps and the next word starts a new frame.
//   m_axis carries one result per word once the window lag is filled: tdata holds
//   variance (Q.30), center row and column, tuser the center valid flag, tlast marks
//   the frame's final pixel.
//   cfg writes frame_width (index 0) and frame_height (index 1); geometry is sampled at
//   the first word of each frame. Write only while the block is idle.
// Flow:
//   One word is taken at a time. A word that gives no result is at most written to the
//   pixel store. A word that gives a result also has its whole window read through the
//   single pixel-store read port; if its center is valid, the variance unit then runs
//   its multiply and its bit-per-cycle divide before the result goes to the output
//   register.
// Reset clears counters, geometry and the output register; pixel store contents are
// not cleared. When m_axis stalls, the finished result waits in the output register
// and the next input word is still taken and worked on up to its own result.

module masked_window_normal_variance
    import mwnv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // normal_x, normal_y, normal_z
    input  logic                  s_axis_tuser,   // pixel_valid
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // variance, center_row, center_col, zeros
    output logic                  m_axis_tuser,   // center_valid
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_CALC  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic [ADDR_W:0] DEPTH_X = (ADDR_W + 1)'(STORE_DEPTH);
    localparam logic [ADDR_W:0] HALF_X  = (ADDR_W + 1)'(HALF_WINDOW);

    logic [2:0]         state_reg;
    logic [CFG_W-1:0]   frame_width_reg, frame_height_reg;
    logic [WID_W-1:0]   act_w_reg;
    logic [HGT_W-1:0]   act_h_reg;
    logic [PIX_W-1:0]   npix_reg;
    logic [POS_W-1:0]   lag_reg;
    logic [ADDR_W-1:0]  hw_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [ADDR_W-1:0]  wr_addr_reg, c_addr_reg, base_reg;
    logic [ROW_W-1:0]   cr_reg;
    logic [COL_W-1:0]   cc_reg;
    logic [ENTRY_W-1:0] in_word_reg;
    logic [WIN_W-1:0]   k_reg, l_reg;
    logic               drain_reg;
    logic               calc_started_reg;

    logic               out_valid_reg;
    logic [VAR_W-1:0]   out_var_reg;
    logic               out_cv_reg;
    logic [OUT_IDX_W-1:0] out_row_reg, out_col_reg;
    logic               out_last_reg;

    logic [WID_W-1:0]   w_clamp;
    logic [HGT_W-1:0]   h_clamp;
    logic               in_fire;
    logic               store_en;
    logic               produce;
    logic [POS_W-1:0]   pos_inc;
    logic               pos_wrap;
    logic [ADDR_W:0]    base_init;
    logic [ADDR_W:0]    t_addr, u_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W:0]    base_inc;
    logic [GEO_W-1:0]   r_sum, x_sum;
    logic               in_image;
    rd_tag_t            tag;
    logic [ENTRY_W-1:0] rd_data;
    logic               acc_clear;
    win_stat_t          stat;
    logic               var_start, var_done;
    logic [VAR_W-1:0]   variance;
    logic               out_free;
    logic               last_pix;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Clamp geometry into range
    always_comb
    begin
        if (frame_width_reg == '0)
            w_clamp = WID_W'(1);
        else if (EXT_W'(frame_width_reg) > EXT_W'(MAX_WIDTH))
            w_clamp = WID_W'(MAX_WIDTH);
        else
            w_clamp = WID_W'(frame_width_reg);
        if (frame_height_reg == '0)
            h_clamp = HGT_W'(1);
        else if (frame_height_reg > CFG_W'(MAX_HEIGHT))
            h_clamp = HGT_W'(MAX_HEIGHT);
        else
            h_clamp = HGT_W'(frame_height_reg);
    end

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    // Position decisions
    assign store_en = (pos_reg < POS_W'(npix_reg));
    assign produce  = (pos_reg >= lag_reg);
    assign pos_inc  = pos_reg + POS_W'(1);
    assign pos_wrap = (pos_inc >= POS_W'(npix_reg) + lag_reg);

    // Window addressing with wrap into the circular store
    always_comb
    begin
        base_init = {1'b0, c_addr_reg} + DEPTH_X - {1'b0, hw_reg};
        if (base_init >= DEPTH_X)
            base_init = base_init - DEPTH_X;
        t_addr = {1'b0, base_reg} + (ADDR_W + 1)'(l_reg);
        if (t_addr >= HALF_X)
            u_addr = t_addr - HALF_X;
        else
            u_addr = t_addr + DEPTH_X - HALF_X;
        if (u_addr >= DEPTH_X)
            u_addr = u_addr - DEPTH_X;
        base_inc = {1'b0, base_reg} + (ADDR_W + 1)'(act_w_reg);
        if (base_inc >= DEPTH_X)
            base_inc = base_inc - DEPTH_X;
    end

    assign rd_addr = u_addr[ADDR_W-1:0];
    assign r_sum   = GEO_W'(cr_reg) + GEO_W'(k_reg);
    assign x_sum   = GEO_W'(cc_reg) + GEO_W'(l_reg);
    assign in_image = (r_sum >= GEO_W'(HALF_WINDOW))
                   && (r_sum < GEO_W'(act_h_reg) + GEO_W'(HALF_WINDOW))
                   && (x_sum >= GEO_W'(HALF_WINDOW))
                   && (x_sum < GEO_W'(act_w_reg) + GEO_W'(HALF_WINDOW));

    always_comb
    begin
        tag.valid    = (state_reg == ST_READ);
        tag.in_image = in_image;
        tag.center   = (k_reg == WIN_W'(HALF_WINDOW)) && (l_reg == WIN_W'(HALF_WINDOW));
    end

    assign acc_clear = (state_reg == ST_STORE) && produce;
    assign var_start = (state_reg == ST_CALC) && !calc_started_reg;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign last_pix  = (GEO_W'(cr_reg) == GEO_W'(act_h_reg) - GEO_W'(1))
                    && (GEO_W'(cc_reg) == GEO_W'(act_w_reg) - GEO_W'(1));

    // Pixel store
    mwnv_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   ((state_reg == ST_STORE) && store_en),
        .wr_addr (wr_addr_reg),
        .wr_data (in_word_reg),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mwnv_acc u_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (acc_clear),
        .tag     (tag),
        .rd_data (rd_data),
        .stat    (stat)
    );

    mwnv_var u_var (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (var_start),
        .stat     (stat),
        .done     (var_done),
        .variance (variance)
    );

    // Hold the accepted word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_word_reg <= {s_axis_tuser, s_axis_tdata};
        end
    end

    // Sequencer and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            act_w_reg        <= WID_W'(FRAME_WIDTH_RST);
            act_h_reg        <= HGT_W'(FRAME_HEIGHT_RST);
            npix_reg         <= '0;
            lag_reg          <= '0;
            hw_reg           <= '0;
            pos_reg          <= '0;
            wr_addr_reg      <= '0;
            c_addr_reg       <= '0;
            base_reg         <= '0;
            cr_reg           <= '0;
            cc_reg           <= '0;
            k_reg            <= '0;
            l_reg            <= '0;
            drain_reg        <= 1'b0;
            calc_started_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (pos_reg == '0)
                        begin
                            act_w_reg <= w_clamp;
                            act_h_reg <= h_clamp;
                        end
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    npix_reg  <= PIX_W'(act_w_reg) * PIX_W'(act_h_reg);
                    hw_reg    <= ADDR_W'(HALF_WINDOW * act_w_reg);
                    lag_reg   <= POS_W'(HALF_WINDOW * act_w_reg + HALF_WINDOW);
                    state_reg <= ST_STORE;
                end
                ST_STORE:
                begin
                    // Advance stream position and write address
                    if (pos_wrap)
                    begin
                        pos_reg     <= '0;
                        wr_addr_reg <= '0;
                    end
                    else
                    begin
                        pos_reg <= pos_inc;
                        if (store_en)
                        begin
                            wr_addr_reg <= (wr_addr_reg == ADDR_W'(STORE_DEPTH - 1)) ?
                                           '0 : wr_addr_reg + ADDR_W'(1);
                        end
                    end
                    if (produce)
                    begin
                        base_reg  <= base_init[ADDR_W-1:0];
                        k_reg     <= '0;
                        l_reg     <= '0;
                        state_reg <= ST_READ;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_READ:
                begin
                    if (l_reg == WIN_W'(WIN - 1))
                    begin
                        l_reg    <= '0;
                        k_reg    <= k_reg + WIN_W'(1);
                        base_reg <= base_inc[ADDR_W-1:0];
                        if (k_reg == WIN_W'(WIN - 1))
                        begin
                            drain_reg <= 1'b0;
                            state_reg <= ST_DRAIN;
                        end
                    end
                    else
                    begin
                        l_reg <= l_reg + WIN_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    // Let the accumulator pipeline settle
                    drain_reg <= 1'b1;
                    if (drain_reg)
                    begin
                        calc_started_reg <= 1'b0;
                        state_reg        <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    calc_started_reg <= 1'b1;
                    if (var_done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        if (last_pix)
                        begin
                            cr_reg     <= '0;
                            cc_reg     <= '0;
                            c_addr_reg <= '0;
                        end
                        else
                        begin
                            if (WID_W'(cc_reg) == act_w_reg - WID_W'(1))
                            begin
                                cc_reg <= '0;
                                cr_reg <= cr_reg + ROW_W'(1);
                            end
                            else
                            begin
                                cc_reg <= cc_reg + COL_W'(1);
                            end
                            c_addr_reg <= (c_addr_reg == ADDR_W'(STORE_DEPTH - 1)) ?
                                          '0 : c_addr_reg + ADDR_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_OUT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_var_reg  <= variance;
            out_cv_reg   <= stat.cv;
            out_row_reg  <= OUT_IDX_W'(cr_reg);
            out_col_reg  <= OUT_IDX_W'(cc_reg);
            out_last_reg <= last_pix;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_col_reg, out_row_reg, out_var_reg};
    assign m_axis_tuser  = out_cv_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

[tb/masked_window_normal_variance_test.sv]
// Self-checking bench for masked_window_normal_variance: directed table, then random frames.
// Depends on mwnv_pkg and the block's RTL; predicts each result from its own window model unless a typed row gives it.

module masked_window_normal_variance_test;
    import mwnv_pkg::*;

    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

    typedef struct packed {
        logic [VAR_W-1:0] variance;
        logic             center_valid;
        logic [9:0]       row;
        logic [9:0]       col;
        logic             last;
    } var_result_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_W-1:0]      value;
        logic signed [15:0]    nx;
        logic signed [15:0]    ny;
        logic signed [15:0]    nz;
        logic                  pv;
        bit                    typed;
        var_result_t           want;
    } stim_row_t;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd5;
    localparam int HOLD_LEN   = 3000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // normal_x, normal_y, normal_z
    logic                  s_axis_tuser;   // pixel_valid
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // variance, center_row, center_col, zeros
    logic                  m_axis_tuser;   // center_valid
    logic                  m_axis_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    masked_window_normal_variance uut (.*);

    always #2 clk = ~clk;

    // Predictor state
    logic [ENTRY_W-1:0] pixel_store [STORE_DEPTH];
    int unsigned        frame_pos;
    int unsigned        width_reg, height_reg, frame_w, frame_h;

    var_result_t        pending_results[$];
    stim_row_t          stim_table[$];
    int                 mismatches;
    int                 burst_left;
    int                 rand_items;
    bit                 hold_req = 1'b0;

    function automatic int unsigned clamp_geo(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the window model by one accepted word; return 1 when a result is due
    function automatic bit predict_variance(logic signed [15:0] nx, logic signed [15:0] ny,
                                            logic signed [15:0] nz, logic pv,
                                            output var_result_t res);
        int unsigned npix, lag, p, c, cr, cc;
        logic [ENTRY_W-1:0] e;
        longint cnt, sq, s0, s1, s2, num, a, b, d, r, x;
        longint unsigned q;
        bit produced;
        produced = 0;
        if (frame_pos == 0) begin
            frame_w = clamp_geo(width_reg, MAX_WIDTH);
            frame_h = clamp_geo(height_reg, MAX_HEIGHT);
        end
        npix = frame_w * frame_h;
        lag  = HALF_WINDOW * frame_w + HALF_WINDOW;
        p    = frame_pos;
        if (p < npix)
            pixel_store[p % STORE_DEPTH] = {pv, nz, ny, nx};
        if (p >= lag && p - lag < npix) begin
            c  = p - lag;
            cr = c / frame_w;
            cc = c % frame_w;
            e  = pixel_store[c % STORE_DEPTH];
            q  = 0;
            if (e[48]) begin
                cnt = 0; sq = 0; s0 = 0; s1 = 0; s2 = 0;
                for (int k = -HALF_WINDOW; k <= HALF_WINDOW; k++)
                    for (int l = -HALF_WINDOW; l <= HALF_WINDOW; l++) begin
                        r = longint'(cr) + k;
                        x = longint'(cc) + l;
                        if (r < 0 || r >= frame_h || x < 0 || x >= frame_w) continue;
                        e = pixel_store[(r * frame_w + x) % STORE_DEPTH];
                        if (!e[48]) continue;
                        a = $signed(e[15:0]);
                        b = $signed(e[31:16]);
                        d = $signed(e[47:32]);
                        s0 += a; s1 += b; s2 += d;
                        sq += a * a + b * b + d * d;
                        cnt++;
                    end
                num = 4 * (cnt * sq - (s0 * s0 + s1 * s1 + s2 * s2));
                if (num < 0) num = 0;
                q = longint'(num) / (cnt * cnt);
                if (q > VAR_SAT) q = VAR_SAT;
            end
            res.variance     = q[VAR_W-1:0];
            res.center_valid = pixel_store[c % STORE_DEPTH][48];
            res.row          = cr[9:0];
            res.col          = cc[9:0];
            res.last         = (c == npix - 1);
            produced = 1;
        end
        frame_pos = (p + 1 >= npix + lag) ? 0 : p + 1;
        return produced;
    endfunction

    // Write one register through the config channel
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_FRAME_WIDTH) width_reg = 32'(value);
        else if (idx == REG_FRAME_HEIGHT) height_reg = 32'(value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one word in bursts with random gaps; typed rows override the prediction
    task automatic send_word(logic signed [15:0] nx, logic signed [15:0] ny,
                             logic signed [15:0] nz, logic pv,
                             bit typed, var_result_t want);
        var_result_t res;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nz, ny, nx};
        s_axis_tuser  <= pv;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (predict_variance(nx, ny, nz, pv, res))
            pending_results = {pending_results, typed ? want : res};
    endtask

    // Hold the input and wait for every expected word, plus the no-result latency
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_comp;
        case ($urandom_range(0, 9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    task automatic send_frame(int unsigned w, int unsigned h);
        var_result_t none;
        none = '{default: '0};
        for (int unsigned i = 0; i < w * h; i++)
            send_word(rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 6) != 0, 0, none);
        for (int unsigned i = 0; i < HALF_WINDOW * w + HALF_WINDOW; i++)
            send_word(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), 0, none);
        rand_items += w * h + HALF_WINDOW * w + HALF_WINDOW;
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        stim_row_t r;
        r = '{kind: ROW_CFG, index: idx, value: value, default: '0};
        stim_table = {stim_table, r};
    endtask

    task automatic add_pix(logic signed [15:0] nx, logic signed [15:0] ny,
                           logic signed [15:0] nz, logic pv, bit typed,
                           logic [VAR_W-1:0] v, logic cv, logic [9:0] row,
                           logic [9:0] col, logic last);
        stim_row_t r;
        r = '{kind: ROW_PIX, nx: nx, ny: ny, nz: nz, pv: pv, typed: typed, default: '0};
        r.want = '{v, cv, row, col, last};
        stim_table = {stim_table, r};
    endtask

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk) begin
        var_result_t got, exp_res;
        if (m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[30:0], m_axis_tuser, m_axis_tdata[40:31],
                    m_axis_tdata[50:41], m_axis_tlast};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: var=%0d cv=%0d row=%0d col=%0d last=%0d",
                             got.variance, got.center_valid, got.row, got.col, got.last);
            end
            else begin
                exp_res = pending_results.pop_front();
                if (got !== exp_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp var=%0d cv=%0d row=%0d col=%0d last=%0d,",
                                  " got var=%0d cv=%0d row=%0d col=%0d last=%0d"},
                                 exp_res.variance, exp_res.center_valid, exp_res.row,
                                 exp_res.col, exp_res.last, got.variance, got.center_valid,
                                 got.row, got.col, got.last);
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off to back up the input
    initial begin
        int cyc, mode, hold_left;
        bit held;
        cyc = 0;
        mode = 0;
        hold_left = 0;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge clk);
            cyc++;
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            if (hold_req && !held) begin
                held = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                case (mode)
                    0, 1: m_axis_tready <= 1'b1;
                    2: m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    // Run limit
    initial begin
        #3200000;
        $display("masked_window_normal_variance test failed");
        $finish;
    end

    // Main sequence
    initial begin
        mismatches = 0;
        burst_left = 0;
        rand_items = 0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        frame_pos = 0;
        width_reg = FRAME_WIDTH_RST;
        height_reg = FRAME_HEIGHT_RST;
        frame_w = width_reg;
        frame_h = height_reg;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero geometry counts as one pixel: valid centre, then masked centre
        add_cfg(REG_FRAME_WIDTH, 11'd0);
        add_cfg(REG_FRAME_HEIGHT, 11'd0);
        add_pix(16'sd16384, -16'sd16384, 16'sd0, 1'b1, 0, 0, 0, 0, 0, 0);
        repeat (3) add_pix(16'sd1, 16'sd2, 16'sd3, 1'b0, 0, 0, 0, 0, 0, 0);
        add_pix(-16'sd1, -16'sd1, -16'sd1, 1'b1, 1, 31'd0, 1'b1, 10'd0, 10'd0, 1'b1);
        add_pix(16'sd16384, 16'sd16384, 16'sd16384, 1'b0, 0, 0, 0, 0, 0, 0);
        repeat (3) add_pix(16'sd0, 16'sd0, 16'sd0, 1'b1, 0, 0, 0, 0, 0, 0);
        add_pix(16'sd0, 16'sd0, 16'sd0, 1'b0, 1, 31'd0, 1'b0, 10'd0, 10'd0, 1'b1);
        // Two opposite extreme normals saturate; an unknown index is ignored
        add_cfg(REG_FRAME_WIDTH, 11'd2);
        add_cfg(REG_FRAME_HEIGHT, 11'd1);
        add_cfg(REG_UNUSED, 11'h7FF);
        add_pix(16'sd16384, 16'sd16384, 16'sd16384, 1'b1, 0, 0, 0, 0, 0, 0);
        add_pix(-16'sd16384, -16'sd16384, -16'sd16384, 1'b1, 0, 0, 0, 0, 0, 0);
        repeat (4) add_pix(16'sd5, 16'sd5, 16'sd5, 1'b1, 0, 0, 0, 0, 0, 0);
        add_pix(16'sd0, 16'sd0, 16'sd0, 1'b0, 1, VAR_SAT, 1'b1, 10'd0, 10'd0, 1'b0);
        add_pix(16'sd0, 16'sd0, 16'sd0, 1'b0, 1, VAR_SAT, 1'b1, 10'd0, 10'd1, 1'b1);

        // Walk the directed table; config rows wait for the block to go idle
        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_CFG) begin
                drain();
                write_reg(stim_table[i].index, stim_table[i].value);
            end
            else
                send_word(stim_table[i].nx, stim_table[i].ny, stim_table[i].nz,
                          stim_table[i].pv, stim_table[i].typed, stim_table[i].want);
        end

        // Hold off the receiver while a whole frame is offered
        drain();
        write_reg(REG_FRAME_WIDTH, 11'd8);
        write_reg(REG_FRAME_HEIGHT, 11'd6);
        hold_req = 1'b1;
        send_frame(8, 6);

        // Random small frames, geometry changed between some of them
        while (rand_items < 900) begin
            if ($urandom_range(0, 2) != 0) begin
                drain();
                write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(1, 14)));
                write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(1, 10)));
            end
            send_frame(clamp_geo(width_reg, MAX_WIDTH), clamp_geo(height_reg, MAX_HEIGHT));
        end

        drain();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("masked_window_normal_variance test passed");
        else
            $display("masked_window_normal_variance test failed");
        $finish;
    end

endmodule
